### src/rws_pkg.sv
// Shared types and constants for the roulette wheel resampler.
package rws_pkg;

  localparam int MAX_PARTICLES = 1024;
  localparam int ADDR_W        = $clog2(MAX_PARTICLES);
  localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
  localparam int WEIGHT_W      = 32;
  localparam int FRAC_W        = 32;
  localparam int TOTAL_W       = 42;
  localparam int SUM_W         = TOTAL_W + 1;
  localparam int INDEX_W       = 10;
  localparam int HI_W          = TOTAL_W - FRAC_W;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_DRAW = 1'b1
  } req_t;

  typedef enum logic {
    STS_OK    = 1'b0,
    STS_EMPTY = 1'b1
  } status_t;

  // Queued command: data is the weight on loads, the fraction on draws.
  typedef struct packed {
    req_t                req;
    logic                first;
    logic [WEIGHT_W-1:0] data;
  } cmd_t;

endpackage

### src/roulette_wheel_resampler_top.sv
// Roulette wheel resampler top level: input queue front end and execution back end.
// A load transfer stores one Q1.31 weight and adds it to the saturating total while the
// store holds fewer than 1024 weights. A draw transfer is taken from the queue, then the
// target fraction * total is formed in two steps from a 32x32 and a 10x32 product, then
// the walk reads the simple dual-port weight memory one entry per cycle until the running
// sum reaches the target or the last entry is read, then the result register is loaded
// once it is free. An empty store or zero total gives index 0 with status 1. A 2-entry
// queue lets further transfers be accepted during a walk.
module roulette_wheel_resampler_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic                         in_first_of_set,
  input  logic [rws_pkg::WEIGHT_W-1:0] in_weight_value,
  input  logic [rws_pkg::FRAC_W-1:0]   in_draw_fraction,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rws_pkg::INDEX_W-1:0]  out_particle_index,
  output logic                         out_status
);
  import rws_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  rws_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_first_of_set  (in_first_of_set),
    .in_weight_value  (in_weight_value),
    .in_draw_fraction (in_draw_fraction),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop)
  );

  rws_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_cmd              (q_cmd),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_particle_index (out_particle_index),
    .out_status         (out_status)
  );

endmodule

### src/rws_front.sv
// Input side: accepts transfers, classifies them and queues them in a 2-entry FIFO.
module rws_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic                         in_first_of_set,
  input  logic [rws_pkg::WEIGHT_W-1:0] in_weight_value,
  input  logic [rws_pkg::FRAC_W-1:0]   in_draw_fraction,
  output logic                         q_valid,
  output rws_pkg::cmd_t                q_cmd,
  input  logic                         q_pop
);
  import rws_pkg::*;

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic [1:0] fill_nxt;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  assign in_stall = (fill_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = q_mem_r[rd_ptr_r];

  always_comb begin
    cmd_in.req   = in_req_type ? REQ_DRAW : REQ_LOAD;
    cmd_in.first = in_first_of_set;
    cmd_in.data  = in_req_type ? in_draw_fraction : in_weight_value;
  end

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

### src/rws_back.sv
// Execution side: weight store, running total, target multiply, linear walk, result register.
module rws_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  rws_pkg::cmd_t               q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rws_pkg::INDEX_W-1:0] out_particle_index,
  output logic                        out_status
);
  import rws_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_TGT,
    S_WALK,
    S_DONE
  } state_t;

  state_t                state_r;
  logic [WEIGHT_W-1:0]   mem [MAX_PARTICLES];
  logic [WEIGHT_W-1:0]   rdata_r;
  logic [ADDR_W-1:0]     rd_addr;
  logic [CNT_W-1:0]      cnt_r;
  logic [TOTAL_W-1:0]    total_r;
  logic [FRAC_W-1:0]     frac_r;
  logic [2*FRAC_W-1:0]   p_lo_r;
  logic [TOTAL_W-1:0]    p_hi_r;
  logic [TOTAL_W-1:0]    target_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SUM_W-1:0]      sum_nxt;
  logic [ADDR_W-1:0]     idx_r;
  logic [ADDR_W-1:0]     res_idx_r;
  status_t               res_sts_r;
  logic                  out_valid_r;
  logic [INDEX_W-1:0]    out_index_r;
  status_t               out_sts_r;
  logic                  out_free;
  logic                  is_load;
  logic [CNT_W-1:0]      base_cnt;
  logic [TOTAL_W-1:0]    base_tot;
  logic                  has_room;
  logic                  mem_we;
  logic [SUM_W-1:0]      tot_sum;
  logic [TOTAL_W-1:0]    tot_nxt;
  logic                  walk_hit;
  logic                  walk_last;

  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign is_load  = (q_cmd.req == REQ_LOAD);
  assign base_cnt = q_cmd.first ? '0 : cnt_r;
  assign base_tot = q_cmd.first ? '0 : total_r;
  assign has_room = (base_cnt < CNT_W'(MAX_PARTICLES));
  assign mem_we   = q_pop && is_load && has_room;
  assign tot_sum  = SUM_W'(base_tot) + SUM_W'(q_cmd.data);
  assign tot_nxt  = tot_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : tot_sum[TOTAL_W-1:0];

  assign sum_nxt   = sum_r + SUM_W'(rdata_r);
  assign walk_hit  = (sum_nxt >= SUM_W'(target_r));
  assign walk_last = (CNT_W'(idx_r) == (cnt_r - CNT_W'(1)));

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    case (state_r)
      S_WALK:  rd_addr = idx_r + ADDR_W'(1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[base_cnt[ADDR_W-1:0]] <= q_cmd.data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (is_load) begin
              if (has_room) begin
                cnt_r   <= base_cnt + CNT_W'(1);
                total_r <= tot_nxt;
              end else begin
                cnt_r   <= base_cnt;
                total_r <= base_tot;
              end
            end else begin
              frac_r <= q_cmd.data;
              if (cnt_r == '0 || total_r == '0) begin
                res_idx_r <= '0;
                res_sts_r <= STS_EMPTY;
                state_r   <= S_DONE;
              end else begin
                state_r <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          p_lo_r  <= (2*FRAC_W)'(total_r[FRAC_W-1:0]) * (2*FRAC_W)'(frac_r);
          p_hi_r  <= {{FRAC_W{1'b0}}, total_r[TOTAL_W-1:FRAC_W]} * TOTAL_W'(frac_r);
          state_r <= S_TGT;
        end
        S_TGT: begin
          target_r <= p_hi_r + TOTAL_W'(p_lo_r[2*FRAC_W-1:FRAC_W]);
          sum_r    <= '0;
          idx_r    <= '0;
          state_r  <= S_WALK;
        end
        S_WALK: begin
          sum_r <= sum_nxt;
          if (walk_hit || walk_last) begin
            res_idx_r <= idx_r;
            res_sts_r <= STS_OK;
            state_r   <= S_DONE;
          end else begin
            idx_r <= idx_r + ADDR_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_index_r <= INDEX_W'(res_idx_r);
            out_sts_r   <= res_sts_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_particle_index = out_index_r;
  assign out_status         = (out_sts_r == STS_EMPTY);

endmodule

### bench/tb.sv
// Self-checking testbench for the roulette wheel resampler top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rws_pkg::*;

  localparam int RANDOM_ITEMS = 280;
  localparam int LONG_SET     = 256;
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int END_TAIL     = 100;
  localparam int REPORT_CAP   = 100;

  typedef struct {
    logic [INDEX_W-1:0] particle;
    status_t            sts;
  } pick_t;

  logic                clk;
  logic                rst_n            = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic                in_req_type      = 1'b0;
  logic                in_first_of_set  = 1'b0;
  logic [WEIGHT_W-1:0] in_weight_value  = '0;
  logic [FRAC_W-1:0]   in_draw_fraction = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [INDEX_W-1:0]  out_particle_index;
  logic                out_status;

  logic [WEIGHT_W-1:0] wheel_weights [MAX_PARTICLES];
  logic [CNT_W-1:0]    wheel_count = '0;
  logic [TOTAL_W-1:0]  wheel_total = '0;

  pick_t expected_picks [$];
  pick_t arrived;
  int    mismatches     = 0;
  int    send_idle_pct  = 0;
  int    recv_stall_pct = 0;
  int    hold_left      = 0;
  int    cycle_count    = 0;

  roulette_wheel_resampler_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_first_of_set    (in_first_of_set),
    .in_weight_value    (in_weight_value),
    .in_draw_fraction   (in_draw_fraction),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_particle_index (out_particle_index),
    .out_status         (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_CAP) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
  endtask

  // Mirror one accepted transfer; draws queue the particle the wheel should pick.
  function automatic void update_wheel(req_t req, logic first, logic [WEIGHT_W-1:0] weight,
                                       logic [FRAC_W-1:0] fraction);
    logic [TOTAL_W:0]              grown;
    logic [TOTAL_W+FRAC_W-1:0]     scaled;
    logic [TOTAL_W-1:0]            target;
    logic [SUM_W-1:0]              running;
    int                            sel;
    pick_t                         pick;
    if (req == REQ_LOAD) begin
      if (first) begin
        wheel_count = '0;
        wheel_total = '0;
      end
      if (wheel_count < MAX_PARTICLES) begin
        wheel_weights[wheel_count[ADDR_W-1:0]] = weight;
        wheel_count = wheel_count + 1'b1;
        grown = {1'b0, wheel_total} + weight;
        wheel_total = grown[TOTAL_W] ? '1 : grown[TOTAL_W-1:0];
      end
    end else begin
      if (wheel_count == 0 || wheel_total == 0) begin
        pick.particle = '0;
        pick.sts = STS_EMPTY;
      end else begin
        scaled = wheel_total * fraction;
        target = scaled[TOTAL_W+FRAC_W-1:FRAC_W];
        running = '0;
        sel = wheel_count - 1;
        for (int i = 0; i < wheel_count; i++) begin
          running = running + wheel_weights[i];
          if (running >= target) begin
            sel = i;
            break;
          end
        end
        pick.particle = sel[INDEX_W-1:0];
        pick.sts = STS_OK;
      end
      expected_picks = {expected_picks, pick};
    end
  endfunction

  task automatic send_item(req_t req, logic first, logic [WEIGHT_W-1:0] weight,
                           logic [FRAC_W-1:0] fraction);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_first_of_set  <= first;
    in_weight_value  <= weight;
    in_draw_fraction <= fraction;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    update_wheel(req, first, weight, fraction);
  endtask

  task automatic wait_results(int tail);
    in_valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Result side: random stall plus an optional long hold-off.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_picks.size() == 0) begin
        report_mismatch($sformatf("unexpected result index %0d status %0d",
                                  out_particle_index, out_status));
      end else begin
        arrived = expected_picks.pop_front();
        if (out_particle_index !== arrived.particle) begin
          report_mismatch($sformatf("particle_index got %0d want %0d",
                                    out_particle_index, arrived.particle));
        end
        if (out_status !== arrived.sts) begin
          report_mismatch($sformatf("status got %0d want %0d", out_status, arrived.sts));
        end
      end
    end
  end

  task automatic test_empty_store();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(REQ_DRAW, 1'b0, '0, '0);
    send_item(REQ_DRAW, 1'b1, '1, '1);
    wait_results(4);
  endtask

  task automatic test_zero_total();
    send_item(REQ_LOAD, 1'b1, '0, '1);
    send_item(REQ_LOAD, 1'b0, '0, '0);
    send_item(REQ_LOAD, 1'b0, '0, '1);
    send_item(REQ_DRAW, 1'b0, '1, 32'h8000_0000);
    wait_results(4);
  endtask

  task automatic test_field_extremes();
    send_item(REQ_LOAD, 1'b1, 32'hFFFF_FFFF, '0);
    send_item(REQ_LOAD, 1'b0, '0, '1);
    send_item(REQ_LOAD, 1'b0, 32'h8000_0000, '0);
    send_item(REQ_LOAD, 1'b0, 32'h0000_0001, '0);
    send_item(REQ_LOAD, 1'b0, 32'h7FFF_FFFF, '0);
    send_item(REQ_DRAW, 1'b0, '1, '0);
    send_item(REQ_DRAW, 1'b1, '0, '1);
    send_item(REQ_DRAW, 1'b0, '0, 32'h8000_0000);
    send_item(REQ_DRAW, 1'b0, '0, 32'h0000_0001);
    send_item(REQ_DRAW, 1'b0, '0, 32'h5555_5555);
    send_item(REQ_DRAW, 1'b0, '0, 32'hAAAA_AAAA);
    send_item(REQ_DRAW, 1'b0, '0, 32'h4000_0000);
    wait_results(4);
  endtask

  task automatic test_single_particle();
    send_item(REQ_LOAD, 1'b1, 32'h0000_0001, '0);
    send_item(REQ_DRAW, 1'b0, '0, '1);
    wait_results(4);
  endtask

  // Load a long set, then draw across the wheel with long walks.
  task automatic test_long_set();
    send_idle_pct  = 36;
    recv_stall_pct = 36;
    for (int k = 0; k < LONG_SET; k++) begin
      send_item(REQ_LOAD, k == 0, (k % 5 == 0) ? $urandom : 32'hFFFF_FFFF, $urandom);
    end
    send_item(REQ_LOAD, 1'b0, 32'h1234_5678, $urandom);
    send_item(REQ_DRAW, 1'b0, $urandom, '1);
    send_item(REQ_DRAW, 1'b0, $urandom, '0);
    send_item(REQ_DRAW, 1'b0, $urandom, 32'h5555_5555);
    send_item(REQ_DRAW, 1'b0, $urandom, 32'hAAAA_AAAA);
    send_item(REQ_DRAW, 1'b0, $urandom, 32'h8000_0000);
    repeat (3) send_item(REQ_DRAW, $urandom_range(1), $urandom, $urandom);
    send_item(REQ_LOAD, 1'b1, 32'h4000_0000, $urandom);
    send_item(REQ_DRAW, 1'b0, $urandom, '1);
    wait_results(4);
  endtask

  // Receiver holds off while transfers keep coming, so the input side must stall.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 400;
    send_item(REQ_LOAD, 1'b1, $urandom, $urandom);
    repeat (3) send_item(REQ_LOAD, 1'b0, $urandom, $urandom);
    repeat (6) send_item(REQ_DRAW, 1'b0, $urandom, $urandom);
    wait_results(4);
  endtask

  task automatic test_random_sets();
    int              sent;
    int              set_len;
    int              pick;
    int              style;
    bit              fresh;
    bit              zero_set;
    logic [WEIGHT_W-1:0] w;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case (sent * 4 / RANDOM_ITEMS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(req_t'($urandom_range(1)), $urandom_range(1), $urandom, $urandom);
          sent++;
        end
      end else begin
        pick = $urandom_range(99);
        set_len = (pick < 85) ? $urandom_range(1, 12) :
                  (pick < 97) ? $urandom_range(13, 64) : $urandom_range(65, 300);
        fresh    = $urandom_range(99) >= 15;
        zero_set = $urandom_range(99) < 5;
        style    = $urandom_range(3);
        for (int k = 0; k < set_len; k++) begin
          case (style)
            0: w = $urandom;
            1: w = $urandom_range(0, 32'h8000_0000);
            2: w = $urandom_range(0, 255);
            default: w = ($urandom_range(9) == 0) ? '0 : $urandom;
          endcase
          if (zero_set) begin
            w = '0;
          end
          send_item(REQ_LOAD, fresh && k == 0, w, $urandom);
          sent++;
        end
        repeat ($urandom_range(1, 6)) begin
          send_item(REQ_DRAW, $urandom_range(1), $urandom, $urandom);
          sent++;
        end
      end
    end
    wait_results(END_TAIL);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_store();
    test_zero_total();
    test_field_extremes();
    test_single_particle();
    test_long_set();
    test_backpressure();
    test_random_sets();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
